[rtl/core/fau_pkg.sv]
// ----------------------------------------------------------------------------
// fau_pkg: shared types and constants of the fraction arithmetic unit
// operation codes, result field widths and the status of the iterative units
// ----------------------------------------------------------------------------
package fau_pkg;

  localparam int ACTION_W  = 2;
  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 31;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  // status of an iterative unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

[rtl/core/fau_req_if.sv]
// ----------------------------------------------------------------------------
// fau_req_if: request channel of the fraction arithmetic unit
// valid/ready handshake carrying the operation and two signed fractions
// ----------------------------------------------------------------------------
interface fau_req_if #(
  parameter int OPERAND_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic [fau_pkg::ACTION_W-1:0]    action;
  logic signed [OPERAND_WIDTH-1:0] a_numerator;
  logic signed [OPERAND_WIDTH-1:0] a_denominator;
  logic signed [OPERAND_WIDTH-1:0] b_numerator;
  logic signed [OPERAND_WIDTH-1:0] b_denominator;

  modport source (
    output valid, action, a_numerator, a_denominator, b_numerator, b_denominator,
    input  ready
  );

  modport sink (
    input  valid, action, a_numerator, a_denominator, b_numerator, b_denominator,
    output ready
  );
endinterface

[rtl/core/fau_rsp_if.sv]
// ----------------------------------------------------------------------------
// fau_rsp_if: response channel of the fraction arithmetic unit
// valid/ready handshake carrying the reduced fraction and its status
// ----------------------------------------------------------------------------
interface fau_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [fau_pkg::NUM_OUT_W-1:0] result_numerator;
  logic [fau_pkg::DEN_OUT_W-1:0]        result_denominator;
  logic                                status;

  modport source (
    output valid, result_numerator, result_denominator, status,
    input  ready
  );

  modport sink (
    input  valid, result_numerator, result_denominator, status,
    output ready
  );
endinterface

[rtl/core/fraction_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit: signed fraction add, subtract, multiply, divide
// result reduced by its greatest common divisor, sign kept in the numerator
// ----------------------------------------------------------------------------
// usage
//   req_i carries one word: action and two fractions a and b, each field
//   OPERAND_WIDTH bits two's complement. rsp_o returns one word per request:
//   reduced numerator, positive denominator and status (1 on a zero
//   denominator or on division by a zero fraction, then 0/0).
// sequencing
//   one request at a time; req_i.ready is high only while the sequencer idles.
//   gcd passes and divisions run one after another in the shared gcd and
//   divider units. multiply/divide: one gcd pass and two divisions.
//   add/subtract: two gcd passes (the first on OPERAND_WIDTH-bit denominators)
//   and four divisions. errors go straight to the write state; a zero result
//   skips the final reduction.
// reset
//   asynchronous, active low; clears the sequencer and the output valid.
// stall
//   the result sits in an output register; a new request is taken while it
//   waits, and the next result waits in the sequencer until rsp_o drains.
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fau_req_if.sink     req_i,
  fau_rsp_if.source   rsp_o
);

  localparam int W     = OPERAND_WIDTH;
  localparam int VW    = 2 * OPERAND_WIDTH;  // products and reduced values
  localparam int SW    = VW + 1;             // signed sum and signed result
  localparam int NUM_W = fau_pkg::NUM_OUT_W;
  localparam int DEN_W = fau_pkg::DEN_OUT_W;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_GCD1  = 13'b0000000000010,
    S_DIVA  = 13'b0000000000100,
    S_DIVB  = 13'b0000000001000,
    S_MUL1  = 13'b0000000010000,
    S_MUL2  = 13'b0000000100000,
    S_MUL3  = 13'b0000001000000,
    S_SUM   = 13'b0000010000000,
    S_CHECK = 13'b0000100000000,
    S_GCD2  = 13'b0001000000000,
    S_DIVN  = 13'b0010000000000,
    S_DIVD  = 13'b0100000000000,
    S_WRITE = 13'b1000000000000
  } state_e;

  // magnitude of a two's complement operand, the most negative value included
  function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  state_e            state_q, state_d;
  fau_pkg::action_e  act_q, act_d;
  logic              launch_q, launch_d;
  logic              err_q, err_d;
  logic              neg_q, neg_d;
  logic              t1_neg_q, t1_neg_d, t2_neg_q, t2_neg_d;
  logic [W-1:0]      an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [W-1:0]      qa_q, qa_d, qb_q, qb_d;
  logic [VW-1:0]     num_q, num_d, den_q, den_d, aux_q, aux_d, g_q, g_d;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic signed [NUM_W-1:0] out_num_q;
  logic [DEN_W-1:0]  out_den_q;
  logic              out_status_q;

  // incoming word
  logic [W-1:0]      in_an, in_ad, in_bn, in_bd;
  logic              in_an_neg, in_ad_neg, in_bn_neg, in_bd_neg;
  fau_pkg::action_e  in_act;
  logic              in_err, in_addsub;

  // shared units
  logic                  gcd_start, div_start;
  logic [VW-1:0]         gcd_x, gcd_y, gcd_res;
  logic [VW-1:0]         div_dvd, div_quo;
  fau_pkg::unit_status_t gcd_st, div_st;

  // multiplier and adder
  logic [W-1:0]          mul_a, mul_b;
  logic [VW-1:0]         prod;
  logic signed [SW-1:0]  s1, s2, sum;
  logic [SW-1:0]         sum_abs;
  logic                  sum_neg;
  logic signed [SW-1:0]  num_signed;
  logic                  addsub_q;

  assign in_act    = fau_pkg::action_e'(req_i.action);
  assign in_an     = mag_of(req_i.a_numerator);
  assign in_ad     = mag_of(req_i.a_denominator);
  assign in_bn     = mag_of(req_i.b_numerator);
  assign in_bd     = mag_of(req_i.b_denominator);
  assign in_an_neg = req_i.a_numerator[W-1];
  assign in_ad_neg = req_i.a_denominator[W-1];
  assign in_bn_neg = req_i.b_numerator[W-1];
  assign in_bd_neg = req_i.b_denominator[W-1];
  assign in_addsub = (in_act == fau_pkg::ACT_ADD) || (in_act == fau_pkg::ACT_SUB);
  assign in_err    = (in_ad == '0) || (in_bd == '0) ||
                     ((in_act == fau_pkg::ACT_DIV) && (in_bn == '0));

  assign addsub_q  = (act_q == fau_pkg::ACT_ADD) || (act_q == fau_pkg::ACT_SUB);

  // unit operand selection by state
  assign gcd_start = launch_q && ((state_q == S_GCD1) || (state_q == S_GCD2));
  assign div_start = launch_q && !gcd_start;
  assign gcd_x     = (state_q == S_GCD1) ? VW'(ad_q) : num_q;
  assign gcd_y     = (state_q == S_GCD1) ? VW'(bd_q) : den_q;

  always_comb begin
    case (state_q)
      S_DIVA:  div_dvd = VW'(ad_q);
      S_DIVB:  div_dvd = VW'(bd_q);
      S_DIVN:  div_dvd = num_q;
      default: div_dvd = den_q;
    endcase
  end

  // cross products; add/sub scales each numerator by the other reduced denominator
  always_comb begin
    case (state_q)
      S_MUL1: begin
        mul_a = an_q;
        if (addsub_q) begin
          mul_b = qb_q;
        end else if (act_q == fau_pkg::ACT_MUL) begin
          mul_b = bn_q;
        end else begin
          mul_b = bd_q;
        end
      end
      S_MUL2: begin
        if (addsub_q) begin
          mul_a = bn_q;
          mul_b = qa_q;
        end else if (act_q == fau_pkg::ACT_MUL) begin
          mul_a = ad_q;
          mul_b = bd_q;
        end else begin
          mul_a = bn_q;
          mul_b = ad_q;
        end
      end
      default: begin
        // least common multiple of the denominators
        mul_a = qa_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod = VW'(mul_a) * VW'(mul_b);

  // signed sum of the two scaled numerators
  assign s1      = t1_neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
  assign s2      = t2_neg_q ? -$signed({1'b0, aux_q}) : $signed({1'b0, aux_q});
  assign sum     = s1 + s2;
  assign sum_neg = sum[SW-1];
  assign sum_abs = sum_neg ? (~sum + SW'(1)) : sum;

  assign num_signed = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

  // sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    err_d       = err_q;
    neg_d       = neg_q;
    t1_neg_d    = t1_neg_q;
    t2_neg_d    = t2_neg_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    num_d       = num_q;
    den_d       = den_q;
    aux_d       = aux_q;
    g_d         = g_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d    = in_act;
          an_d     = in_an;
          ad_d     = in_ad;
          bn_d     = in_bn;
          bd_d     = in_bd;
          t1_neg_d = in_an_neg ^ in_ad_neg;
          t2_neg_d = in_bn_neg ^ in_bd_neg ^ (in_act == fau_pkg::ACT_SUB);
          // multiply and divide share the same sign rule
          neg_d    = in_an_neg ^ in_ad_neg ^ in_bn_neg ^ in_bd_neg;
          err_d    = in_err;
          if (in_err) begin
            state_d = S_WRITE;
          end else if (in_addsub) begin
            state_d = S_GCD1;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_GCD1: begin
        if (gcd_st.done) begin
          g_d     = gcd_res;
          state_d = S_DIVA;
        end
      end
      S_DIVA: begin
        if (div_st.done) begin
          qa_d    = div_quo[W-1:0];
          state_d = S_DIVB;
        end
      end
      S_DIVB: begin
        if (div_st.done) begin
          qb_d    = div_quo[W-1:0];
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        num_d   = prod;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        if (addsub_q) begin
          aux_d   = prod;
          state_d = S_MUL3;
        end else begin
          den_d   = prod;
          state_d = S_CHECK;
        end
      end
      S_MUL3: begin
        den_d   = prod;
        state_d = S_SUM;
      end
      S_SUM: begin
        num_d   = sum_abs[VW-1:0];
        neg_d   = sum_neg;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // zero result goes out as 0/1
        if (num_q == '0) begin
          den_d   = VW'(1);
          neg_d   = 1'b0;
          state_d = S_WRITE;
        end else begin
          state_d = S_GCD2;
        end
      end
      S_GCD2: begin
        if (gcd_st.done) begin
          g_d     = gcd_res;
          state_d = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_st.done) begin
          num_d   = div_quo;
          state_d = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_st.done) begin
          den_d   = div_quo;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // one start pulse on entry to a unit state
    launch_d = (state_d != state_q) &&
               ((state_d == S_GCD1) || (state_d == S_GCD2) ||
                (state_d == S_DIVA) || (state_d == S_DIVB) ||
                (state_d == S_DIVN) || (state_d == S_DIVD));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    err_q    <= err_d;
    neg_q    <= neg_d;
    t1_neg_q <= t1_neg_d;
    t2_neg_q <= t2_neg_d;
    an_q     <= an_d;
    ad_q     <= ad_d;
    bn_q     <= bn_d;
    bd_q     <= bd_d;
    qa_q     <= qa_d;
    qb_q     <= qb_d;
    num_q    <= num_d;
    den_q    <= den_d;
    aux_q    <= aux_d;
    g_q      <= g_d;
    if (out_load) begin
      if (err_q) begin
        out_num_q    <= '0;
        out_den_q    <= '0;
        out_status_q <= 1'b1;
      end else begin
        out_num_q    <= NUM_W'(num_signed);
        out_den_q    <= DEN_W'(den_q);
        out_status_q <= 1'b0;
      end
    end
  end

  fau_gcd #(
    .WIDTH (VW)
  ) u_gcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gcd_start),
    .x_i      (gcd_x),
    .y_i      (gcd_y),
    .gcd_o    (gcd_res),
    .status_o (gcd_st)
  );

  fau_div #(
    .WIDTH (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (g_q),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  assign req_i.ready              = (state_q == S_IDLE);
  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.result_numerator   = out_num_q;
  assign rsp_o.result_denominator = out_den_q;
  assign rsp_o.status             = out_status_q;

  // a unit is never restarted while it still iterates
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gcd_start |-> !gcd_st.busy) and (div_start |-> !div_st.busy))
    else $error("unit started while busy");

  // gcd completes only while the sequencer waits on it
  a_gcd_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_st.done |-> (state_q == S_GCD1) || (state_q == S_GCD2))
    else $error("gcd done outside a gcd state");

  // divider completes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == S_DIVA) || (state_q == S_DIVB) ||
                    (state_q == S_DIVN) || (state_q == S_DIVD))
    else $error("divider done outside a divide state");

  // a new result appears only from the write state
  a_out_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WRITE))
    else $error("result valid without write state");

endmodule

[rtl/core/fau_gcd.sv]
// ----------------------------------------------------------------------------
// fau_gcd: iterative binary greatest common divisor
// one halve or subtract-and-halve step per cycle, both inputs nonzero
// ----------------------------------------------------------------------------
module fau_gcd #(
  parameter int WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WIDTH-1:0]      x_i,
  input  logic [WIDTH-1:0]      y_i,
  output logic [WIDTH-1:0]      gcd_o,
  output fau_pkg::unit_status_t status_o
);

  localparam int KW = $clog2(WIDTH);

  logic [WIDTH-1:0] x_q, x_d, y_q, y_d, g_q, g_d;
  logic [KW-1:0]    k_q, k_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    g_d    = g_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x_i;
      y_d    = y_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (x_q == y_q) begin
        g_d    = x_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!x_q[0] && !y_q[0]) begin
        // common factor of two
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + KW'(1);
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q > y_q) begin
        x_d = (x_q - y_q) >> 1;
      end else begin
        y_d = (y_q - x_q) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign gcd_o         = g_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

[rtl/core/fau_div.sv]
// ----------------------------------------------------------------------------
// fau_div: restoring unsigned divider
// one quotient bit per cycle, quotient valid when done pulses
// ----------------------------------------------------------------------------
module fau_div #(
  parameter int WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WIDTH-1:0]      dividend_i,
  input  logic [WIDTH-1:0]      divisor_i,
  output logic [WIDTH-1:0]      quotient_o,
  output fau_pkg::unit_status_t status_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_q, rem_d, dvd_q, dvd_d, dsr_q, dsr_d;
  logic [WIDTH:0]   trial;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             fits;

  assign trial = {rem_q, dvd_q[WIDTH-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = CW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits shift in where dividend bits leave
      rem_d = fits ? WIDTH'(trial - {1'b0, dsr_q}) : trial[WIDTH-1:0];
      dvd_d = {dvd_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o    = dvd_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
